/* hw/rtl/bfsd_pkg.sv */
// Shared constants, codes and controller/datapath types for the search-and-drain queue.
package bfsd_pkg;

	localparam int KEY_W       = 32;
	localparam int TIME_W      = 16;
	localparam int OCC_W       = 5;
	localparam int DEPTH_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int NRES_W      = $clog2(MAX_RESULTS);

	localparam logic [1:0] REQ_PUSH   = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_SEARCH = 2'd2;
	localparam logic [1:0] REQ_DRAIN  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_NOKEY = 2'd3;

	typedef struct packed {
		logic       ld_req;
		logic       push_wr;
		logic       rd_head;
		logic       rd_next;
		logic       hold;
		logic       pop_adv;
		logic       srch_init;
		logic       srch_step;
		logic       emit;
		logic       emit_item;
		logic       emit_last;
		logic [1:0] emit_status;
	} bfsd_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       full;
		logic       empty;
		logic       more_one;
		logic       head_le;
		logic       n_last;
		logic       srch_done;
		logic       found;
		logic       out_free;
	} bfsd_stat_t;

endpackage

/* hw/rtl/bfsd_ifs.sv */
// Valid/ready channel interfaces for the request and result transactions.
interface bfsd_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       req_type;
	logic [bfsd_pkg::KEY_W-1:0]       key_in;
	logic [bfsd_pkg::TIME_W-1:0]      time_in;

	modport source(output valid, req_type, key_in, time_in, input ready);
	modport sink(input valid, req_type, key_in, time_in, output ready);
endinterface

interface bfsd_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       status;
	logic                             item_valid;
	logic [bfsd_pkg::KEY_W-1:0]       key_out;
	logic [bfsd_pkg::TIME_W-1:0]      time_out;
	logic [bfsd_pkg::OCC_W-1:0]       occupancy;
	logic                             is_full;
	logic                             is_empty;
	logic                             last;

	modport source(output valid, status, item_valid, key_out, time_out, occupancy,
		is_full, is_empty, last, input ready);
	modport sink(input valid, status, item_valid, key_out, time_out, occupancy,
		is_full, is_empty, last, output ready);
endinterface

/* hw/rtl/bfsd_dp.sv */
// Datapath: entry memory, pointers, count, search walker, drain hold and result register.
module bfsd_dp #(
	parameter int QUEUE_DEPTH = bfsd_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfsd_pkg::bfsd_cmd_t           cmd,
	output bfsd_pkg::bfsd_stat_t          st,
	input  logic [1:0]                    req_type,
	input  logic [bfsd_pkg::KEY_W-1:0]    key_in,
	input  logic [bfsd_pkg::TIME_W-1:0]   time_in,
	bfsd_rsp_if.source                    rsp
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [bfsd_pkg::KEY_W-1:0]  key_mem [QUEUE_DEPTH];
	logic [bfsd_pkg::TIME_W-1:0] time_mem [QUEUE_DEPTH];

	logic [1:0]                   req_type_q;
	logic [bfsd_pkg::KEY_W-1:0]   key_q;
	logic [bfsd_pkg::TIME_W-1:0]  time_q;
	logic [PTR_W-1:0]             head_q, tail_q, srch_p_q;
	logic [PTR_W-1:0]             head_nxt, tail_nxt, srch_p_nxt, rd_addr;
	logic [CNT_W-1:0]             cnt_q, cnt_nxt, srch_idx_q;
	logic [bfsd_pkg::NRES_W-1:0]  n_q;
	logic                         srch_pend_q, found_q, srch_rd, rd_en;
	logic [bfsd_pkg::KEY_W-1:0]   rd_key_q, hold_key_q;
	logic [bfsd_pkg::TIME_W-1:0]  rd_time_q, hold_time_q;
	logic                         out_valid_q, out_free;

	assign head_nxt   = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt   = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign srch_p_nxt = (srch_p_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : srch_p_q + 1'b1;

	assign srch_rd = cmd.srch_step && (srch_idx_q < cnt_q);
	assign rd_en   = cmd.rd_head || cmd.rd_next || srch_rd;
	assign rd_addr = cmd.rd_head ? head_q : (cmd.rd_next ? head_nxt : srch_p_q);

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.push_wr) begin
			cnt_nxt = cnt_q + 1'b1;
		end else if (cmd.pop_adv) begin
			cnt_nxt = cnt_q - 1'b1;
		end
	end

	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		st.req_type  = req_type_q;
		st.full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
		st.empty     = (cnt_q == '0);
		st.more_one  = (cnt_q > CNT_W'(1));
		st.head_le   = (rd_time_q <= time_q);
		st.n_last    = (n_q == bfsd_pkg::NRES_W'(bfsd_pkg::MAX_RESULTS - 1));
		st.srch_done = (srch_idx_q == cnt_q) && !srch_pend_q;
		st.found     = found_q;
		st.out_free  = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			req_type_q <= req_type;
			key_q      <= key_in;
			time_q     <= time_in;
		end
		if (cmd.push_wr) begin
			key_mem[tail_q]  <= key_q;
			time_mem[tail_q] <= time_q;
		end
		if (rd_en) begin
			rd_key_q  <= key_mem[rd_addr];
			rd_time_q <= time_mem[rd_addr];
		end
		if (cmd.hold) begin
			hold_key_q  <= rd_key_q;
			hold_time_q <= rd_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			n_q         <= '0;
			srch_p_q    <= '0;
			srch_idx_q  <= '0;
			srch_pend_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (cmd.push_wr) begin
				tail_q <= tail_nxt;
			end
			if (cmd.ld_req) begin
				n_q <= '0;
			end else if (cmd.pop_adv) begin
				head_q <= head_nxt;
				n_q    <= n_q + 1'b1;
			end
			if (cmd.srch_init) begin
				srch_p_q    <= head_q;
				srch_idx_q  <= '0;
				srch_pend_q <= 1'b0;
				found_q     <= 1'b0;
			end else begin
				srch_pend_q <= srch_rd;
				if (srch_rd) begin
					srch_p_q   <= srch_p_nxt;
					srch_idx_q <= srch_idx_q + 1'b1;
				end
				if (srch_pend_q && (rd_key_q == key_q)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp.status     <= cmd.emit_status;
			rsp.item_valid <= cmd.emit_item;
			rsp.key_out    <= cmd.emit_item ? hold_key_q : '0;
			rsp.time_out   <= cmd.emit_item ? hold_time_q : '0;
			rsp.occupancy  <= bfsd_pkg::OCC_W'(cnt_nxt);
			rsp.is_full    <= (cnt_nxt == CNT_W'(QUEUE_DEPTH));
			rsp.is_empty   <= (cnt_nxt == '0);
			rsp.last       <= cmd.emit_last;
		end
	end

	assign rsp.valid = out_valid_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("Entry count exceeds the queue depth.");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> !st.full)
		else $error("Entry written into a full queue.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_adv |-> !st.empty)
		else $error("Entry removed from an empty queue.");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("Result register overwritten before its transaction completed.");

	a_ptr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (head_q == tail_q))
		else $error("Pointers disagree on an empty queue.");

endmodule

/* hw/rtl/bfsd_ctrl.sv */
// Controller state machine that sequences each request over the datapath.
module bfsd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  bfsd_pkg::bfsd_stat_t   st,
	output bfsd_pkg::bfsd_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISP     = 3'd1;
	localparam logic [2:0] S_POP_HOLD = 3'd2;
	localparam logic [2:0] S_POP_OUT  = 3'd3;
	localparam logic [2:0] S_SRCH     = 3'd4;
	localparam logic [2:0] S_D_CHK    = 3'd5;
	localparam logic [2:0] S_D_LOOK   = 3'd6;

	logic [2:0] state_q, state_d;
	logic       more;

	assign req_ready = (state_q == S_IDLE);
	assign more      = st.more_one && !st.n_last && st.head_le;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.ld_req = 1'b1;
					state_d    = S_DISP;
				end
			end
			S_DISP: begin
				case (st.req_type)
					bfsd_pkg::REQ_PUSH: begin
						if (st.out_free) begin
							cmd.emit        = 1'b1;
							cmd.emit_last   = 1'b1;
							cmd.push_wr     = !st.full;
							cmd.emit_status = st.full ? bfsd_pkg::ST_FULL : bfsd_pkg::ST_OK;
							state_d         = S_IDLE;
						end
					end
					bfsd_pkg::REQ_POP, bfsd_pkg::REQ_DRAIN: begin
						if (st.empty) begin
							if (st.out_free) begin
								cmd.emit        = 1'b1;
								cmd.emit_last   = 1'b1;
								cmd.emit_status = bfsd_pkg::ST_EMPTY;
								state_d         = S_IDLE;
							end
						end else begin
							cmd.rd_head = 1'b1;
							state_d     = (st.req_type == bfsd_pkg::REQ_POP) ? S_POP_HOLD
								: S_D_CHK;
						end
					end
					bfsd_pkg::REQ_SEARCH: begin
						cmd.srch_init = 1'b1;
						state_d       = S_SRCH;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_POP_HOLD: begin
				cmd.hold = 1'b1;
				state_d  = S_POP_OUT;
			end
			S_POP_OUT: begin
				if (st.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_item   = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = bfsd_pkg::ST_OK;
					cmd.pop_adv     = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_SRCH: begin
				cmd.srch_step = 1'b1;
				if (st.srch_done && st.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = st.found ? bfsd_pkg::ST_OK : bfsd_pkg::ST_NOKEY;
					state_d         = S_IDLE;
				end
			end
			S_D_CHK: begin
				if (st.head_le) begin
					cmd.hold    = 1'b1;
					cmd.rd_next = st.more_one && !st.n_last;
					state_d     = S_D_LOOK;
				end else if (st.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = bfsd_pkg::ST_OK;
					state_d         = S_IDLE;
				end
			end
			S_D_LOOK: begin
				if (st.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_item   = 1'b1;
					cmd.emit_last   = !more;
					cmd.emit_status = bfsd_pkg::ST_OK;
					cmd.pop_adv     = 1'b1;
					state_d         = more ? S_D_CHK : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/bounded_fifo_search_drain_unit.sv */
// Top level of the bounded queue with key search and time-ordered drain.
// A request transaction on req carries req_type, key_in and time_in; results
// leave as transactions on rsp, one per request, or one per removed entry
// for a drain that removes any; last is set on each request's final result.
// Requests are taken one at a time: req.ready is high only while the unit is
// idle. A push gives its result from the dispatch state, a pop reads and
// then holds the head entry, and a search walks the entry memory, which
// has one registered read port, one entry per cycle. A drain reads the head
// entry, and while removing each entry it reads the one behind it.
// A finished result waits in an output register, so the next request can be
// accepted while it is still held; if rsp.ready stays low, the unit stalls
// at the next result it must hand over and nothing is lost or reordered.
// Asynchronous reset empties the queue and clears pending results; the
// stored entries themselves are not cleared and need no clearing pass.
// The result fields reflect the occupancy after each push or removal.
module bounded_fifo_search_drain_unit #(
	parameter int QUEUE_DEPTH = bfsd_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bfsd_req_if.sink    req,
	bfsd_rsp_if.source  rsp
);

	bfsd_pkg::bfsd_cmd_t  cmd;
	bfsd_pkg::bfsd_stat_t st;
	logic                 req_ready;

	assign req.ready = req_ready;

	bfsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	bfsd_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.req_type (req.req_type),
		.key_in   (req.key_in),
		.time_in  (req.time_in),
		.rsp      (rsp)
	);

endmodule
